// File: hdl/crk_pkg.sv
// Shared types and constants for the Catmull-Rom keyframe interpolator.
`timescale 1ns / 1ps

package crk_pkg;

  localparam int KEY_DEPTH_DEF = 64;
  localparam int COORDS        = 6;
  localparam int DIV_STEPS     = 16;
  localparam int ACC_W         = 40;

  typedef struct packed {
    logic [31:0]              tm;
    logic [COORDS-1:0][31:0]  pt;
  } key_row_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEY0,
    ST_LAST,
    ST_SCAN,
    ST_LOAD,
    ST_DIV,
    ST_MAC,
    ST_PUB
  } state_t;

  typedef enum logic [2:0] {
    MAC_NONE,
    MAC_LOADC,
    MAC_MUL,
    MAC_ADDB,
    MAC_ADDA,
    MAC_ADDP,
    MAC_SAT
  } mac_op_t;

  typedef struct packed {
    logic        wr_key;
    logic        q_load;
    logic        stage_zero;
    logic        stage_key;
    logic        row_cap;
    logic [1:0]  row_slot;
    logic        div_init;
    logic        div_step;
    mac_op_t     mac_op;
    logic [2:0]  coord;
    logic [5:0]  seg;
    logic        publish;
  } cmd_t;

  typedef struct packed {
    logic q_le_rd;
    logic q_ge_rd;
    logic rd_gt_q;
  } sts_t;

  function automatic mac_op_t phase_op(input logic [2:0] ph);
    mac_op_t op;
    begin
      op = MAC_NONE;
      unique case (ph)
        3'd0: op = MAC_LOADC;
        3'd1, 3'd3, 3'd5: op = MAC_MUL;
        3'd2: op = MAC_ADDB;
        3'd4: op = MAC_ADDA;
        3'd6: op = MAC_ADDP;
        3'd7: op = MAC_SAT;
        default: op = MAC_NONE;
      endcase
      return op;
    end
  endfunction

endpackage

// File: hdl/crk_dp.sv
// Datapath: key memory, segment rows, serial divider and shared Horner multiplier.
`timescale 1ns / 1ps

module crk_dp #(
  parameter int KEY_DEPTH = crk_pkg::KEY_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic [5:0]                   in_key_index,
  input  logic [31:0]                  in_key_time,
  input  logic signed [31:0]           in_key_pos_x,
  input  logic signed [31:0]           in_key_pos_y,
  input  logic signed [31:0]           in_key_pos_z,
  input  logic signed [31:0]           in_key_tgt_x,
  input  logic signed [31:0]           in_key_tgt_y,
  input  logic signed [31:0]           in_key_tgt_z,
  input  logic [31:0]                  in_query_time,
  input  crk_pkg::cmd_t                cmd,
  input  logic [$clog2(KEY_DEPTH)-1:0] rd_addr,
  output crk_pkg::sts_t                sts,
  output logic signed [31:0]           out_pos_x,
  output logic signed [31:0]           out_pos_y,
  output logic signed [31:0]           out_pos_z,
  output logic signed [31:0]           out_tgt_x,
  output logic signed [31:0]           out_tgt_y,
  output logic signed [31:0]           out_tgt_z,
  output logic [5:0]                   out_segment_start
);

  localparam int AW = $clog2(KEY_DEPTH);
  localparam int AC = crk_pkg::ACC_W;
  localparam int PW = AC + 17;

  crk_pkg::key_row_t mem [KEY_DEPTH];
  crk_pkg::key_row_t rd_data_r;
  crk_pkg::key_row_t wr_row;
  crk_pkg::key_row_t rows_r [4];

  logic [10:0] wr_idx;
  logic        wr_ok;
  logic [31:0] q_r;

  logic [32:0] rem_r;
  logic [32:0] rem_sh;
  logic [15:0] quot_r;
  logic [31:0] den;

  logic signed [AC-1:0] acc_r;
  logic signed [AC-1:0] acc_nxt;
  logic signed [PW-1:0] prod_r;
  logic signed [AC-1:0] p0, p1, p2, p3;
  logic signed [AC-1:0] coef_a, coef_b, coef_c, addend;
  logic signed [AC-1:0] half;
  logic signed [31:0]   sat_val;

  logic [crk_pkg::COORDS-1:0][31:0] res_r;
  logic [5:0]                       seg_res_r;
  logic [crk_pkg::COORDS-1:0][31:0] out_pt_r;
  logic [5:0]                       out_seg_r;

  assign wr_idx = {5'd0, in_key_index};
  assign wr_ok  = wr_idx < 11'(KEY_DEPTH);

  always_comb begin
    wr_row.tm    = in_key_time;
    wr_row.pt[0] = in_key_pos_x;
    wr_row.pt[1] = in_key_pos_y;
    wr_row.pt[2] = in_key_pos_z;
    wr_row.pt[3] = in_key_tgt_x;
    wr_row.pt[4] = in_key_tgt_y;
    wr_row.pt[5] = in_key_tgt_z;
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_key && wr_ok) begin
      mem[wr_idx[AW-1:0]] <= wr_row;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign sts.q_le_rd = q_r <= rd_data_r.tm;
  assign sts.q_ge_rd = q_r >= rd_data_r.tm;
  assign sts.rd_gt_q = rd_data_r.tm > q_r;

  // restoring division of (q - t1) << 16 by (t2 - t1), one quotient bit a step
  assign den    = rows_r[2].tm - rows_r[1].tm;
  assign rem_sh = {rem_r[31:0], 1'b0};

  always_ff @(posedge clk) begin
    if (cmd.q_load) begin
      q_r <= in_query_time;
    end
    if (cmd.row_cap) begin
      rows_r[cmd.row_slot] <= rd_data_r;
    end
    if (cmd.div_init) begin
      rem_r  <= {1'b0, q_r - rows_r[1].tm};
      quot_r <= '0;
    end else if (cmd.div_step) begin
      if (rem_sh >= {1'b0, den}) begin
        rem_r  <= rem_sh - {1'b0, den};
        quot_r <= {quot_r[14:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        quot_r <= {quot_r[14:0], 1'b0};
      end
    end
  end

  always_comb begin
    p0 = AC'($signed(rows_r[0].pt[cmd.coord]));
    p1 = AC'($signed(rows_r[1].pt[cmd.coord]));
    p2 = AC'($signed(rows_r[2].pt[cmd.coord]));
    p3 = AC'($signed(rows_r[3].pt[cmd.coord]));
    coef_a = p2 - p0;
    coef_b = (p0 <<< 1) - ((p1 <<< 2) + p1) + (p2 <<< 2) - p3;
    coef_c = ((p1 <<< 1) + p1) - ((p2 <<< 1) + p2) + p3 - p0;
    case (cmd.mac_op)
      crk_pkg::MAC_ADDB: addend = coef_b;
      crk_pkg::MAC_ADDA: addend = coef_a;
      crk_pkg::MAC_ADDP: addend = p1 <<< 1;
      default:           addend = '0;
    endcase
    acc_nxt = AC'(prod_r >>> 16) + addend;
    half    = acc_r >>> 1;
    if (half > AC'(64'sh7FFFFFFF)) begin
      sat_val = 32'sh7FFFFFFF;
    end else if (half < -AC'(64'sh80000000)) begin
      sat_val = 32'sh80000000;
    end else begin
      sat_val = half[31:0];
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.mac_op)
      crk_pkg::MAC_LOADC: acc_r <= coef_c;
      crk_pkg::MAC_MUL:   prod_r <= acc_r * $signed({1'b0, quot_r});
      crk_pkg::MAC_ADDB,
      crk_pkg::MAC_ADDA,
      crk_pkg::MAC_ADDP:  acc_r <= acc_nxt;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.stage_zero) begin
      res_r     <= '0;
      seg_res_r <= '0;
    end else if (cmd.stage_key) begin
      res_r     <= rd_data_r.pt;
      seg_res_r <= cmd.seg;
    end else if (cmd.mac_op == crk_pkg::MAC_SAT) begin
      res_r[cmd.coord] <= sat_val;
      seg_res_r        <= cmd.seg;
    end
    if (cmd.publish) begin
      out_pt_r  <= res_r;
      out_seg_r <= seg_res_r;
    end
  end

  assign out_pos_x         = out_pt_r[0];
  assign out_pos_y         = out_pt_r[1];
  assign out_pos_z         = out_pt_r[2];
  assign out_tgt_x         = out_pt_r[3];
  assign out_tgt_y         = out_pt_r[4];
  assign out_tgt_z         = out_pt_r[5];
  assign out_segment_start = out_seg_r;

endmodule

// File: hdl/crk_ctrl.sv
// Controller: sequences search, row loads, division and Horner steps.
`timescale 1ns / 1ps

module crk_ctrl #(
  parameter int KEY_DEPTH = crk_pkg::KEY_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_action,
  input  logic                         cfg_wr_en,
  input  logic [6:0]                   cfg_wr_data,
  input  logic                         out_stall,
  input  crk_pkg::sts_t                sts,
  output crk_pkg::cmd_t                cmd,
  output logic [$clog2(KEY_DEPTH)-1:0] rd_addr,
  output logic                         in_stall,
  output logic                         out_valid
);

  localparam int AW = $clog2(KEY_DEPTH);
  localparam int CW = $clog2(KEY_DEPTH + 1);

  crk_pkg::state_t state_r, state_nxt;
  logic [6:0]    key_count_r;
  logic [AW-1:0] chk_r, chk_nxt;
  logic [AW-1:0] i0_r, i1_r, i2_r, i3_r;
  logic [AW-1:0] i0_nxt, i1_nxt, i2_nxt, i3_nxt;
  logic [4:0]    cnt_r, cnt_nxt;
  logic [2:0]    coord_r, coord_nxt;
  logic [2:0]    phase_r, phase_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [CW-1:0] n;
  logic [AW-1:0] last;
  logic          accept;
  logic          found;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= crk_pkg::ST_IDLE;
      key_count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        key_count_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_r   <= chk_nxt;
    i0_r    <= i0_nxt;
    i1_r    <= i1_nxt;
    i2_r    <= i2_nxt;
    i3_r    <= i3_nxt;
    cnt_r   <= cnt_nxt;
    coord_r <= coord_nxt;
    phase_r <= phase_nxt;
  end

  assign n      = ({4'd0, key_count_r} > 11'(KEY_DEPTH)) ? CW'(KEY_DEPTH) : CW'(key_count_r);
  assign last   = AW'(n - CW'(1));
  assign accept = in_valid && !in_stall;
  assign found  = sts.rd_gt_q || (chk_r == last);

  assign in_stall  = state_r != crk_pkg::ST_IDLE;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    chk_nxt       = chk_r;
    i0_nxt        = i0_r;
    i1_nxt        = i1_r;
    i2_nxt        = i2_r;
    i3_nxt        = i3_r;
    cnt_nxt       = cnt_r;
    coord_nxt     = coord_r;
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.mac_op    = crk_pkg::MAC_NONE;
    cmd.coord     = coord_r;
    rd_addr       = '0;

    unique case (state_r)
      crk_pkg::ST_IDLE: begin
        if (accept && !in_action) begin
          cmd.wr_key = 1'b1;
        end else if (accept) begin
          cmd.q_load = 1'b1;
          if (n == '0) begin
            cmd.stage_zero = 1'b1;
            state_nxt      = crk_pkg::ST_PUB;
          end else begin
            state_nxt = crk_pkg::ST_KEY0;
          end
        end
      end
      crk_pkg::ST_KEY0: begin
        rd_addr = last;
        if (n == CW'(1) || sts.q_le_rd) begin
          cmd.stage_key = 1'b1;
          state_nxt     = crk_pkg::ST_PUB;
        end else begin
          state_nxt = crk_pkg::ST_LAST;
        end
      end
      crk_pkg::ST_LAST: begin
        rd_addr = AW'(1);
        chk_nxt = AW'(1);
        if (sts.q_ge_rd) begin
          cmd.stage_key = 1'b1;
          cmd.seg       = 6'(last);
          state_nxt     = crk_pkg::ST_PUB;
        end else begin
          state_nxt = crk_pkg::ST_SCAN;
        end
      end
      crk_pkg::ST_SCAN: begin
        rd_addr = chk_r + AW'(1);
        chk_nxt = chk_r + AW'(1);
        if (found) begin
          i2_nxt    = chk_r;
          i1_nxt    = chk_r - AW'(1);
          i0_nxt    = (chk_r == AW'(1)) ? '0 : chk_r - AW'(2);
          i3_nxt    = ((CW'(chk_r) + CW'(1)) < n) ? chk_r + AW'(1) : last;
          cnt_nxt   = '0;
          state_nxt = crk_pkg::ST_LOAD;
        end
      end
      crk_pkg::ST_LOAD: begin
        case (cnt_r[1:0])
          2'd0:    rd_addr = i0_r;
          2'd1:    rd_addr = i1_r;
          2'd2:    rd_addr = i2_r;
          default: rd_addr = i3_r;
        endcase
        cmd.row_cap  = cnt_r != '0;
        cmd.row_slot = 2'(cnt_r - 5'd1);
        cnt_nxt      = cnt_r + 5'd1;
        if (cnt_r == 5'd4) begin
          cmd.div_init = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = crk_pkg::ST_DIV;
        end
      end
      crk_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 5'd1;
        if (cnt_r == 5'(crk_pkg::DIV_STEPS - 1)) begin
          coord_nxt = '0;
          phase_nxt = '0;
          state_nxt = crk_pkg::ST_MAC;
        end
      end
      crk_pkg::ST_MAC: begin
        cmd.mac_op = crk_pkg::phase_op(phase_r);
        cmd.seg    = 6'(i1_r);
        phase_nxt  = phase_r + 3'd1;
        if (phase_r == 3'd7) begin
          coord_nxt = coord_r + 3'd1;
          if (coord_r == 3'(crk_pkg::COORDS - 1)) begin
            state_nxt = crk_pkg::ST_PUB;
          end
        end
      end
      crk_pkg::ST_PUB: begin
        if (!out_valid_r || !out_stall) begin
          cmd.publish   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = crk_pkg::ST_IDLE;
        end
      end
      default: state_nxt = crk_pkg::ST_IDLE;
    endcase
  end

endmodule

// File: hdl/catmull_rom_keyframe_interpolator.sv
// Top level of the Catmull-Rom keyframe interpolator.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_*): one request per accepted edge (in_valid high, in_stall
//   low). in_action 0 writes a keyframe into slot in_key_index; in_action 1
//   evaluates the spline at in_query_time. cfg_wr_en/cfg_wr_data set key_count;
//   write it only while the block is idle.
//   Result channel (out_*): one result per evaluate request, none per write.
//   Request flow:
//     write request: the next request is taken on the following cycle.
//     empty table: the zero result goes straight to publish; early clamped query:
//     stops at the compare with key 0; late clamped query: stops at the last key.
//     interior query: the key scan runs up to k, the first later key's index,
//     at one memory read a cycle; the neighbor row loads, the 16-step divider
//     and the shared Horner multiplier over six coordinates follow.
//   in_stall stays high while an evaluate request is in flight.
//   When the receiver stalls, the result holds in the output register; a new
//   request is still accepted and computed, and it waits to publish until the
//   held result is taken.
//   Reset clears the controller state, key_count and out_valid. The key memory is
//   not cleared; entries read before written hold unknown data.
module catmull_rom_keyframe_interpolator #(
  parameter int KEY_DEPTH = crk_pkg::KEY_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_action,
  input  logic [5:0]         in_key_index,
  input  logic [31:0]        in_key_time,
  input  logic signed [31:0] in_key_pos_x,
  input  logic signed [31:0] in_key_pos_y,
  input  logic signed [31:0] in_key_pos_z,
  input  logic signed [31:0] in_key_tgt_x,
  input  logic signed [31:0] in_key_tgt_y,
  input  logic signed [31:0] in_key_tgt_z,
  input  logic [31:0]        in_query_time,
  input  logic               cfg_wr_en,
  input  logic [6:0]         cfg_wr_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic signed [31:0] out_tgt_x,
  output logic signed [31:0] out_tgt_y,
  output logic signed [31:0] out_tgt_z,
  output logic [5:0]         out_segment_start
);

  crk_pkg::cmd_t                cmd;
  crk_pkg::sts_t                sts;
  logic [$clog2(KEY_DEPTH)-1:0] rd_addr;

  // sequence the request: search, load the four neighbor rows, divide, blend
  crk_ctrl #(.KEY_DEPTH(KEY_DEPTH)) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_action   (in_action),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_stall   (out_stall),
    .sts         (sts),
    .cmd         (cmd),
    .rd_addr     (rd_addr),
    .in_stall    (in_stall),
    .out_valid   (out_valid)
  );

  // hold keys, compute the segment parameter and the saturated spline points
  crk_dp #(.KEY_DEPTH(KEY_DEPTH)) u_dp (
    .clk               (clk),
    .in_key_index      (in_key_index),
    .in_key_time       (in_key_time),
    .in_key_pos_x      (in_key_pos_x),
    .in_key_pos_y      (in_key_pos_y),
    .in_key_pos_z      (in_key_pos_z),
    .in_key_tgt_x      (in_key_tgt_x),
    .in_key_tgt_y      (in_key_tgt_y),
    .in_key_tgt_z      (in_key_tgt_z),
    .in_query_time     (in_query_time),
    .cmd               (cmd),
    .rd_addr           (rd_addr),
    .sts               (sts),
    .out_pos_x         (out_pos_x),
    .out_pos_y         (out_pos_y),
    .out_pos_z         (out_pos_z),
    .out_tgt_x         (out_tgt_x),
    .out_tgt_y         (out_tgt_y),
    .out_tgt_z         (out_tgt_z),
    .out_segment_start (out_segment_start)
  );

`ifndef ASSERT_OFF
  // no result is pending right after reset
  a_reset_quiet: assert property (@(posedge clk) (rst_n && $past(!rst_n)) |-> !out_valid)
    else $error("result valid right after reset");

  // a keyframe write leaves the input channel free in the next cycle
  a_write_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !in_action) |=> !in_stall)
    else $error("stall raised after a write request");

  // an evaluate request holds off the input channel
  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_action) |=> in_stall)
    else $error("no stall after an evaluate request");
`endif

endmodule

// File: bench/catmull_rom_keyframe_interpolator_tb.sv
// Self-checking testbench for the Catmull-Rom keyframe interpolator.
`timescale 1ns / 1ps

module catmull_rom_keyframe_interpolator_tb;

  localparam int DEPTH       = 64;
  localparam int IDLE_LIMIT  = 3000;   // cycles without any handshake
  localparam int CFG_SETTLE  = 160;    // idle margin before a key_count write
  localparam bit ACT_WRITE   = 1'b0;
  localparam bit ACT_EVAL    = 1'b1;

  typedef struct packed {
    logic [5:0][31:0] pt;
    logic [5:0]       seg;
  } point_set_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_action;
  logic [5:0]         in_key_index;
  logic [31:0]        in_key_time;
  logic signed [31:0] in_key_pos_x, in_key_pos_y, in_key_pos_z;
  logic signed [31:0] in_key_tgt_x, in_key_tgt_y, in_key_tgt_z;
  logic [31:0]        in_query_time;
  logic               cfg_wr_en;
  logic [6:0]         cfg_wr_data;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;
  logic signed [31:0] out_tgt_x, out_tgt_y, out_tgt_z;
  logic [5:0]         out_segment_start;

  catmull_rom_keyframe_interpolator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action),
    .in_key_index(in_key_index), .in_key_time(in_key_time),
    .in_key_pos_x(in_key_pos_x), .in_key_pos_y(in_key_pos_y),
    .in_key_pos_z(in_key_pos_z), .in_key_tgt_x(in_key_tgt_x),
    .in_key_tgt_y(in_key_tgt_y), .in_key_tgt_z(in_key_tgt_z),
    .in_query_time(in_query_time),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_pos_z(out_pos_z),
    .out_tgt_x(out_tgt_x), .out_tgt_y(out_tgt_y), .out_tgt_z(out_tgt_z),
    .out_segment_start(out_segment_start)
  );

  // Shadow copy of the key table and the key count.
  logic [31:0]        shadow_tm [DEPTH];
  logic [5:0][31:0]   shadow_pt [DEPTH];
  logic [6:0]         shadow_count;

  point_set_t pending_points[$];

  int mismatches;
  int n_writes, n_evals, n_checked, n_cfg;
  int idle_cycles;
  bit quiet_sender;     // phase with back-to-back requests
  int stall_left;
  int stall_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Predictor: uniform Catmull-Rom in Q16.16 with floored Horner steps.
  // ---------------------------------------------------------------------
  function automatic logic [31:0] spline_coord(longint p0, longint p1, longint p2,
                                               longint p3, longint t);
    longint a, b, c, r;
    a = p2 - p0;
    b = 2 * p0 - 5 * p1 + 4 * p2 - p3;
    c = -p0 + 3 * p1 - 3 * p2 + p3;
    // arithmetic shift right gives floor division by 2^16
    r = ((c * t) >>> 16) + b;
    r = ((r * t) >>> 16) + a;
    r = ((r * t) >>> 16) + 2 * p1;
    r = r >>> 1;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  function automatic point_set_t predict_points(logic [31:0] q);
    point_set_t res;
    int n, i0, i1, i2, i3;
    longint unsigned num, den;
    longint t;
    res = '0;
    n = (shadow_count > DEPTH) ? DEPTH : shadow_count;
    if (n == 0) return res;
    if (n == 1 || q <= shadow_tm[0]) begin
      res.pt = shadow_pt[0];
      res.seg = 6'd0;
      return res;
    end
    if (q >= shadow_tm[n-1]) begin
      res.pt = shadow_pt[n-1];
      res.seg = 6'(n - 1);
      return res;
    end
    // linear scan for the first later key
    i2 = n - 1;
    for (int k = 1; k < n; k++) begin
      if (shadow_tm[k] > q) begin
        i2 = k;
        break;
      end
    end
    i1 = i2 - 1;
    i0 = (i1 > 0) ? i1 - 1 : i1;
    i3 = (i2 + 1 < n) ? i2 + 1 : n - 1;
    num = q - shadow_tm[i1];
    den = shadow_tm[i2] - shadow_tm[i1];
    t = (den == 0 || num >= den) ? 0 : longint'((num << 16) / den);
    for (int k = 0; k < 6; k++)
      res.pt[k] = spline_coord($signed(shadow_pt[i0][k]), $signed(shadow_pt[i1][k]),
                               $signed(shadow_pt[i2][k]), $signed(shadow_pt[i3][k]), t);
    res.seg = 6'(i1);
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Request driver. Called at a rising edge; returns at the accepting edge
  // with in_valid still high.
  // ---------------------------------------------------------------------
  task automatic send_request(bit act, logic [5:0] idx, logic [31:0] tm,
                              logic [5:0][31:0] pt, logic [31:0] q);
    int gap, roll;
    roll = $urandom_range(99);
    if (quiet_sender || roll < 55) gap = 0;
    else if (roll < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(5, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= act;
    in_key_index  <= idx;
    in_key_time   <= tm;
    in_key_pos_x  <= pt[0];
    in_key_pos_y  <= pt[1];
    in_key_pos_z  <= pt[2];
    in_key_tgt_x  <= pt[3];
    in_key_tgt_y  <= pt[4];
    in_key_tgt_z  <= pt[5];
    in_query_time <= q;
    do @(posedge clk); while (in_stall);
    // request taken at this edge: advance the shadow state
    if (act == ACT_WRITE) begin
      shadow_tm[idx] = tm;
      shadow_pt[idx] = pt;
      n_writes++;
    end else begin
      pending_points.insert(pending_points.size(), predict_points(q));
      n_evals++;
    end
  endtask

  task automatic write_key(int idx, logic [31:0] tm, logic [5:0][31:0] pt);
    send_request(ACT_WRITE, 6'(idx), tm, pt, $urandom);
  endtask

  task automatic evaluate(logic [31:0] q);
    logic [5:0][31:0] junk;
    for (int k = 0; k < 6; k++) junk[k] = $urandom;
    send_request(ACT_EVAL, 6'($urandom), $urandom, junk, q);
  endtask

  // Change key_count only with nothing in flight.
  task automatic set_key_count(logic [6:0] cnt);
    in_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (CFG_SETTLE) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cnt;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    shadow_count = cnt;
    n_cfg++;
  endtask

  function automatic logic [31:0] rand_coord();
    int mode;
    mode = $urandom_range(9);
    case (mode)
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3, 4: return $urandom;
      default: return 32'($signed($urandom_range(0, 32'h3FF_FFFF)) - 32'sh200_0000);
    endcase
  endfunction

  function automatic logic [5:0][31:0] rand_points();
    logic [5:0][31:0] p;
    for (int k = 0; k < 6; k++) p[k] = rand_coord();
    return p;
  endfunction

  // Load the whole table with strictly increasing times.
  task automatic load_ordered_table(logic [31:0] start, int max_step);
    logic [31:0] tm;
    tm = start;
    for (int k = 0; k < DEPTH; k++) begin
      write_key(k, tm, rand_points());
      tm = tm + $urandom_range(1, max_step);
    end
  endtask

  function automatic logic [31:0] rand_query();
    int n, k, roll;
    n = (shadow_count > DEPTH) ? DEPTH : shadow_count;
    roll = $urandom_range(99);
    if (n == 0 || roll < 8) return $urandom;
    if (roll < 11) return 32'h0;
    if (roll < 14) return 32'hFFFF_FFFF;
    k = $urandom_range(n - 1);
    if (roll < 24) return shadow_tm[k];
    // mostly inside the loaded span, near a key
    return shadow_tm[k] + $urandom_range(0, 32'h0200_0000) - 32'h0040_0000;
  endfunction

  // ---------------------------------------------------------------------
  // Result side: random stall and checking.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(99) < stall_pct) begin
      out_stall  <= 1'b1;
      stall_left <= ($urandom_range(9) == 0) ? $urandom_range(10, 50) : $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    point_set_t want, got;
    if (rst_n && out_valid && !out_stall) begin
      got.pt  = {out_tgt_z, out_tgt_y, out_tgt_x, out_pos_z, out_pos_y, out_pos_x};
      got.seg = out_segment_start;
      if (pending_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result at %0t", $realtime);
      end else begin
        want = pending_points.pop_front();
        n_checked++;
        for (int k = 0; k < 7; k++) begin
          logic [31:0] w, g;
          w = (k < 6) ? want.pt[k] : 32'(want.seg);
          g = (k < 6) ? got.pt[k] : 32'(got.seg);
          if (w !== g) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: result %0d field %0d expected %h got %h",
                       n_checked, k, w, g);
          end
        end
      end
    end
  end

  // Watchdog: end the run when no handshake happens for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("ERROR: no progress for %0d cycles", IDLE_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  task automatic test_empty_table();
    evaluate(32'h0);
    evaluate(32'hFFFF_FFFF);
    set_key_count(7'd0);
    evaluate($urandom);
  endtask

  task automatic test_single_key();
    write_key(0, 32'h0001_0000, {32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF,
                                 32'h0000_0001, 32'h1234_5678});
    set_key_count(7'd1);
    evaluate(32'h0);
    evaluate(32'hFFFF_FFFF);
    evaluate(32'h0001_0000);
  endtask

  task automatic test_directed_table();
    // extreme coordinates drive the saturation path
    for (int k = 0; k < DEPTH; k++)
      write_key(k, 32'h0010_0000 + 32'(k) * 32'h0001_0000,
                (k % 2) ? {6{32'h7FFF_FFFF}} : {6{32'h8000_0000}});
    set_key_count(7'd64);
    evaluate(32'h0);                 // early
    evaluate(32'h0010_0000);         // at first key
    evaluate(32'h0010_8000);         // interior, end segment clamps
    evaluate(32'h0030_4000);         // interior
    evaluate(32'h004F_0000);         // at last key
    evaluate(32'hFFFF_FFFF);         // late
    set_key_count(7'd2);             // both neighbors clamp
    evaluate(32'h0010_C000);
    set_key_count(7'd127);           // oversized count acts as full depth
    evaluate(32'h004E_FFFF);
    evaluate(32'h004F_0001);
  endtask

  task automatic test_random_phases();
    logic [6:0] counts[8] = '{7'd0, 7'd1, 7'd2, 7'd3, 7'd64, 7'd127, 7'd5, 7'd16};
    for (int ph = 0; ph < 16; ph++) begin
      quiet_sender = (ph % 5 == 3);
      stall_pct = (ph % 4 == 1) ? 0 : ((ph % 4 == 2) ? 60 : 20);
      if (ph % 3 == 0)
        load_ordered_table($urandom_range(0, 32'h4000_0000),
                           (ph % 2) ? 32'h40 : 32'h0100_0000);
      set_key_count((ph < 8) ? counts[ph] : 7'($urandom_range(0, 127)));
      repeat (37) begin
        if ($urandom_range(99) < 8)
          // single rewrite with random content, times may end up unordered
          write_key($urandom_range(DEPTH - 1),
                    ($urandom_range(1)) ? $urandom : shadow_tm[$urandom_range(DEPTH - 1)],
                    rand_points());
        else
          evaluate(rand_query());
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0; in_action = ACT_WRITE; in_key_index = '0; in_key_time = '0;
    in_key_pos_x = '0; in_key_pos_y = '0; in_key_pos_z = '0;
    in_key_tgt_x = '0; in_key_tgt_y = '0; in_key_tgt_z = '0;
    in_query_time = '0; cfg_wr_en = 1'b0; cfg_wr_data = '0;
    shadow_count = '0; stall_pct = 20; quiet_sender = 1'b0;
    mismatches = 0; n_writes = 0; n_evals = 0; n_checked = 0; n_cfg = 0;
    for (int k = 0; k < DEPTH; k++) begin
      shadow_tm[k] = '0;
      shadow_pt[k] = '0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_single_key();
    test_directed_table();
    test_random_phases();

    // drain outstanding results, then let the pipe settle
    in_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (CFG_SETTLE) @(posedge clk);

    $display("Covered %0d key writes, %0d evaluations (%0d checked), %0d count updates.",
             n_writes, n_evals, n_checked, n_cfg);
    $display("Mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
